### rtl/whbs_pkg.sv
// Shared types and constants of the wrapped height-map bilinear sampler.
package whbs_pkg;

  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned POS_W    = 16;

  typedef enum logic [1:0] {
    MODE_WR_GROUND = 2'd0,
    MODE_WR_OBJECT = 2'd1,
    MODE_RD_GROUND = 2'd2,
    MODE_RD_OBJECT = 2'd3
  } mode_t;

  // bit 0 selects the x+1 column, bit 1 the z+1 row
  typedef enum logic [1:0] {
    CORNER_00 = 2'd0,
    CORNER_10 = 2'd1,
    CORNER_01 = 2'd2,
    CORNER_11 = 2'd3
  } corner_t;

  typedef struct packed {
    logic    load;
    logic    step;
    logic    wr;
    logic    rd;
    corner_t rd_corner;
    logic    cap;
    corner_t cap_corner;
    logic    blend_x;
    logic    blend_z;
  } cmd_t;

  typedef struct packed {
    logic query;
    logic out_busy;
  } sts_t;

endpackage

### rtl/whbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module whbs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/whbs_ctrl.sv
// Controller state machine sequencing reduction, map access and blending.
module whbs_ctrl
  import whbs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_REDUCE,
    S_WRITE,
    S_RD00,
    S_RD10,
    S_RD01,
    S_RD11,
    S_CAP11,
    S_BLX,
    S_BLZ
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.step  = 1'b1;
        state_nxt = sts.query ? S_RD00 : S_WRITE;
      end
      S_WRITE: begin
        cmd.wr    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RD00: begin
        cmd.rd        = 1'b1;
        cmd.rd_corner = CORNER_00;
        state_nxt     = S_RD10;
      end
      S_RD10: begin
        cmd.rd         = 1'b1;
        cmd.rd_corner  = CORNER_10;
        cmd.cap        = 1'b1;
        cmd.cap_corner = CORNER_00;
        state_nxt      = S_RD01;
      end
      S_RD01: begin
        cmd.rd         = 1'b1;
        cmd.rd_corner  = CORNER_01;
        cmd.cap        = 1'b1;
        cmd.cap_corner = CORNER_10;
        state_nxt      = S_RD11;
      end
      S_RD11: begin
        cmd.rd         = 1'b1;
        cmd.rd_corner  = CORNER_11;
        cmd.cap        = 1'b1;
        cmd.cap_corner = CORNER_01;
        state_nxt      = S_CAP11;
      end
      S_CAP11: begin
        cmd.cap        = 1'b1;
        cmd.cap_corner = CORNER_11;
        state_nxt      = S_BLX;
      end
      S_BLX: begin
        cmd.blend_x = 1'b1;
        state_nxt   = S_BLZ;
      end
      S_BLZ: begin
        if (!sts.out_busy) begin
          cmd.blend_z = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

### rtl/whbs_dp.sv
// Datapath: coordinate wrap, map storage, corner capture and bilinear blend.
module whbs_dp
  import whbs_pkg::*;
#(
  parameter int unsigned GRID_SIZE = 256,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [1:0]          in_mode,
  input  logic [POS_W-1:0]    in_pos_x,
  input  logic [POS_W-1:0]    in_pos_z,
  input  logic [HEIGHT_W-1:0] in_write_height,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [HEIGHT_W-1:0] out_height
);

  localparam int unsigned IW    = POS_W - FRAC_BITS;
  localparam int unsigned GW    = $clog2(GRID_SIZE);
  localparam int unsigned CW    = $clog2(GRID_SIZE * GRID_SIZE);
  localparam int unsigned AW    = CW + 1;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned RS    = IW + GW;
  localparam int unsigned RMW   = IW + 2;
  localparam int unsigned PW    = IW + RMW;
  localparam logic [63:0] RECIP = ((64'd1 << RS) + 64'(GRID_SIZE) - 64'd1) / 64'(GRID_SIZE);

  logic [IW-1:0]        rx_r, rz_r;
  logic [FRAC_BITS-1:0] fx_r, fz_r;
  mode_t                mode_r;
  logic [HEIGHT_W-1:0]  wh_r;
  logic [HEIGHT_W-1:0]  c00_r, c10_r, c01_r, c11_r;
  logic [HEIGHT_W-1:0]  v1_r, v2_r;
  logic [HEIGHT_W-1:0]  height_r;
  logic                 out_valid_r;

  logic [GW-1:0]       ix, iz, cx, cz, sx, sz;
  logic                map_sel;
  logic [CW-1:0]       cell_idx;
  logic [AW-1:0]       addr;
  logic [HEIGHT_W-1:0] rdata;
  corner_t             corner;

  function automatic logic [HEIGHT_W-1:0] blend(input logic [HEIGHT_W-1:0] a,
                                                input logic [HEIGHT_W-1:0] b,
                                                input logic [FRAC_BITS-1:0] f);
    logic signed [HEIGHT_W:0]            d;
    logic signed [HEIGHT_W+FRAC_BITS+1:0] p;
    logic signed [HEIGHT_W+FRAC_BITS+1:0] q;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = d * $signed({1'b0, f});
    q = p >>> FRAC_BITS;
    return a + q[HEIGHT_W-1:0];
  endfunction

  // reduce modulo GRID_SIZE by reciprocal multiplication
  function automatic logic [IW-1:0] wrap_int(input logic [IW-1:0] v);
    logic [PW-1:0] prod;
    logic [IW-1:0] quo;
    prod = PW'(v) * PW'(RECIP);
    quo  = IW'(prod >> RS);
    return v - IW'(32'(quo) * GRID_SIZE);
  endfunction

  assign ix = GW'(rx_r);
  assign iz = GW'(rz_r);
  assign cx = (ix == GW'(GRID_SIZE - 1)) ? '0 : ix + GW'(1);
  assign cz = (iz == GW'(GRID_SIZE - 1)) ? '0 : iz + GW'(1);

  assign corner   = cmd.wr ? CORNER_00 : cmd.rd_corner;
  assign sx       = corner[0] ? cx : ix;
  assign sz       = corner[1] ? cz : iz;
  assign cell_idx = CW'(sx) * CW'(GRID_SIZE) + CW'(sz);
  assign map_sel  = (mode_r == MODE_WR_OBJECT) || (mode_r == MODE_RD_OBJECT);
  assign addr     = {map_sel, cell_idx};

  whbs_ram #(
    .WIDTH(HEIGHT_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.wr),
    .waddr(addr),
    .wdata(wh_r),
    .re   (cmd.rd),
    .raddr(addr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rx_r   <= in_pos_x[POS_W-1:FRAC_BITS];
      rz_r   <= in_pos_z[POS_W-1:FRAC_BITS];
      fx_r   <= in_pos_x[FRAC_BITS-1:0];
      fz_r   <= in_pos_z[FRAC_BITS-1:0];
      mode_r <= mode_t'(in_mode);
      wh_r   <= in_write_height;
    end else if (cmd.step) begin
      rx_r <= wrap_int(rx_r);
      rz_r <= wrap_int(rz_r);
    end
    if (cmd.cap) begin
      case (cmd.cap_corner)
        CORNER_00: c00_r <= rdata;
        CORNER_10: c10_r <= rdata;
        CORNER_01: c01_r <= rdata;
        CORNER_11: c11_r <= rdata;
        default:   c00_r <= rdata;
      endcase
    end
    if (cmd.blend_x) begin
      v1_r <= blend(c00_r, c10_r, fx_r);
      v2_r <= blend(c01_r, c11_r, fx_r);
    end
    if (cmd.blend_z) begin
      height_r <= blend(v1_r, v2_r, fz_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.blend_z) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.query    = (mode_r == MODE_RD_GROUND) || (mode_r == MODE_RD_OBJECT);
  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_height   = height_r;

  a_wrapped_x: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd || cmd.wr) |-> (32'(rx_r) < GRID_SIZE) && (32'(rz_r) < GRID_SIZE))
    else $error("coordinate not wrapped before map access");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.blend_z |-> !(out_valid_r && !out_ready))
    else $error("result overwritten while stalled");

  a_between: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.blend_z |=> ((height_r >= v1_r) && (height_r <= v2_r)) ||
                    ((height_r >= v2_r) && (height_r <= v1_r)))
    else $error("blended height outside row values");

  a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr && cmd.rd))
    else $error("map read and write in the same cycle");

endmodule

### rtl/wrapped_heightmap_bilinear_sampler.sv
// Top level of the wrapped height-map bilinear sampler.
// Input channel (in_valid/in_ready) carries one word per item: in_mode
// selects a ground or object cell write, or a ground or object query, with
// unsigned fixed-point in_pos_x/in_pos_z and in_write_height.
// Result channel (out_valid/out_ready) carries one out_height word per query;
// writes produce no word.
// Both coordinates wrap modulo GRID_SIZE in the reduce step by reciprocal
// multiplication.
// The four corners then come out of one single-port-read map memory one per
// cycle, followed by one x-blend and one z-blend step.
// A query passes through the reduce, corner read, final capture, x-blend and
// z-blend states, and a write through the reduce and write states, before the
// next word is taken. One item is in flight at a time.
// The result sits in an output register, so the next item is accepted while
// it waits; a further query holds in its final blend step until the receiver
// takes the pending word.
// Reset clears the controller and out_valid; map contents are undefined until
// written and must be written before they are queried.
module wrapped_heightmap_bilinear_sampler
  import whbs_pkg::*;
#(
  parameter int unsigned GRID_SIZE = 256,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_mode,
  input  logic [POS_W-1:0]    in_pos_x,
  input  logic [POS_W-1:0]    in_pos_z,
  input  logic [HEIGHT_W-1:0] in_write_height,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [HEIGHT_W-1:0] out_height
);

  cmd_t cmd;
  sts_t sts;

  whbs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  whbs_dp #(
    .GRID_SIZE(GRID_SIZE),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_mode        (in_mode),
    .in_pos_x       (in_pos_x),
    .in_pos_z       (in_pos_z),
    .in_write_height(in_write_height),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_height     (out_height)
  );

endmodule
